// File: rtl/alm_pkg.sv
// Shared types, widths and register codes of the audio level meter.
package alm_pkg;

	// Sample and channel geometry.
	localparam int SAMPLE_BITS   = 16;
	localparam int MAX_CHANNELS  = 8;
	localparam int CH_W          = 3;

	// Per-channel state widths.
	localparam int ACC_W   = 31;
	localparam int LVL_W   = 16;
	localparam int AGE_W   = 16;
	localparam int ENTRY_W = AGE_W + LVL_W + ACC_W;

	// Register widths.
	localparam int BW_W     = 14;
	localparam int RF_W     = 16;
	localparam int HF_W     = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_METER_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RMS_FACTOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 3'd4;

	// Register reset values.
	localparam logic [BW_W-1:0] BAR_WIDTH_RST  = 14'd400;
	localparam logic [RF_W-1:0] RMS_FACTOR_RST = 16'd14862;

	// Fixed-point constants.
	localparam logic [ACC_W-1:0] ACC_MAX  = 31'h4000_0000;
	localparam logic [LVL_W-1:0] FULL_Q15 = 16'h8000;

	typedef struct packed {
		logic [CH_W-1:0]               channel;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          frame_end;
	} alm_in_t;

	typedef struct packed {
		logic [CH_W-1:0]  out_channel;
		logic [LVL_W-1:0] level;
		logic [BW_W-1:0]  bar_position;
		logic [BW_W-1:0]  hold_position;
		logic             hold_valid;
	} alm_out_t;

endpackage

// File: rtl/alm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module alm_ram import alm_pkg::*; #(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = MAX_CHANNELS,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/alm_bar.sv
// Bar position unit: scales a Q1.15 level by the bar width, registered.
module alm_bar import alm_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [LVL_W-1:0] lvl,
	input  logic [BW_W-1:0]  bar_width,
	input  logic             vertical,
	output logic [BW_W-1:0]  pos_q
);

	localparam int PROD_W = BW_W + LVL_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_up;
	logic [BW_W-1:0]   pos_d;

	always_comb begin
		prod    = PROD_W'(bar_width) * PROD_W'(lvl);
		// Round up for the vertical offset so the bar never overshoots the top.
		prod_up = prod + PROD_W'(FULL_Q15 - 16'd1);
		if (vertical) begin
			pos_d = bar_width - prod_up[15 +: BW_W];
		end else begin
			pos_d = prod[15 +: BW_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_q <= pos_d;
		end
	end

endmodule

// File: rtl/audio_level_meter_peak_hold_core.sv
// Top level of the per-channel audio level meter with peak hold.
//
// Usage: samples arrive as beats on the in channel (in_valid/in_ready,
// payload in_beat). Each beat carries a channel index, a signed sample and a
// frame-end mark. Level reports leave as beats on the out channel
// (out_valid/out_ready, payload out_beat), one per accepted frame-end beat of
// a channel below MAX_CHANNELS. Beats for other channels are dropped.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while the
// block is idle; unknown indexes are ignored.
// Per-channel state (accumulator, held level, hold age) lives in one RAM
// with a registered read; each beat does a read, two multiply stages and a
// write-back, one beat at a time, so there is no overlap on an entry.
// A beat without frame end runs through the read-modify-write sequence of
// the state RAM; a frame-end beat also passes the bar scaling stage and
// the emit state. A dropped beat is taken while idle and leaves it idle.
// The report sits in an output register; while the receiver stalls, the
// block finishes the next beat up to its write-back and waits only when a
// further report has to be loaded.
// Reset: registers take their reset values and a valid bit per channel makes
// every RAM entry read as zero until it is first written; no clearing pass.
module audio_level_meter_peak_hold_core import alm_pkg::*; #(
	parameter int MAX_CH = MAX_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  alm_in_t              in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output alm_out_t             out_beat,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW     = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;
	localparam int CHX_W  = AW + CH_W;
	localparam int MAG_W  = SAMPLE_BITS;
	localparam int SQF_W  = 2 * SAMPLE_BITS;
	localparam int SQ_R   = (2 * SAMPLE_BITS >= 32) ? 2 * SAMPLE_BITS - 32 : 0;
	localparam int SQ_L   = (2 * SAMPLE_BITS >= 32) ? 0 : 32 - 2 * SAMPLE_BITS;
	localparam int MUL_W  = ACC_W + RF_W;

	// One-hot sequencer through the read-modify-write of one beat.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_UPD  = 6'b001000,
		ST_BAR  = 6'b010000,
		ST_EMIT = 6'b100000
	} alm_state_t;

	alm_state_t state_q, state_d;

	// Configuration registers.
	logic            meter_mode_q;
	logic [BW_W-1:0] bar_width_q;
	logic            vertical_q;
	logic [RF_W-1:0] rms_factor_q;
	logic [HF_W-1:0] hold_frames_q;

	// Beat held for the duration of its processing.
	logic [CH_W-1:0]               ch_q;
	logic [AW-1:0]                 addr_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          fe_q;
	logic                          entry_valid_q;
	logic [MAX_CH-1:0]             valid_q;

	// Stage registers.
	logic [ACC_W-1:0] acc_s1, pk_s1, sq_s1;
	logic [LVL_W-1:0] held_s1;
	logic [AGE_W-1:0] age_s1;
	logic [MUL_W-1:0] prod_s2;
	logic             ge_s2;
	logic [LVL_W-1:0] lvl_s3, held_s3;

	logic     out_valid_q;
	alm_out_t out_beat_q;

	// Input side.
	logic             in_acc;
	logic [CHX_W-1:0] ch_ext;
	logic             in_range;
	logic [AW-1:0]    in_addr;

	// RAM.
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata, entry;

	// Read-stage arithmetic.
	logic [MAG_W-1:0] mag;
	logic [SQF_W-1:0] sq_full;
	logic [63:0]      sq_wide;

	// Multiply-stage arithmetic.
	logic [ACC_W-1:0] diff;
	logic             ge;

	// Update-stage arithmetic.
	logic [ACC_W:0]   acc_ms;
	logic [ACC_W:0]   acc_sel;
	logic [ACC_W-1:0] acc_new, acc_wr;
	logic [LVL_W-1:0] lvl;
	logic             hold_en, take;
	logic [LVL_W-1:0] held_new;
	logic [AGE_W-1:0] age_new;
	logic [MUL_W-1:0] prod_up;

	// Output side.
	logic [BW_W-1:0] bar_pos, hold_bar;
	logic [BW_W-1:0] hold_pos;
	logic            out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign ch_ext   = CHX_W'(in_beat.channel);
	assign in_range = ch_ext < CHX_W'(MAX_CH);
	assign in_addr  = ch_ext[AW-1:0];
	assign hold_en  = (hold_frames_q != '0);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_mode_q  <= 1'b0;
			bar_width_q   <= BAR_WIDTH_RST;
			vertical_q    <= 1'b0;
			rms_factor_q  <= RMS_FACTOR_RST;
			hold_frames_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_METER_MODE:  meter_mode_q  <= cfg_data[0];
				REG_BAR_WIDTH:   bar_width_q   <= cfg_data[BW_W-1:0];
				REG_VERTICAL:    vertical_q    <= cfg_data[0];
				REG_RMS_FACTOR:  rms_factor_q  <= cfg_data[RF_W-1:0];
				REG_HOLD_FRAMES: hold_frames_q <= cfg_data[HF_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_range) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_MUL;
			ST_MUL:  state_d = ST_UPD;
			ST_UPD:  state_d = fe_q ? ST_BAR : ST_IDLE;
			ST_BAR:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the beat; the valid bit of its entry is sampled with the read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q          <= in_beat.channel;
			addr_q        <= in_addr;
			sample_q      <= in_beat.sample;
			fe_q          <= in_beat.frame_end;
			entry_valid_q <= valid_q[in_addr];
		end
	end

	// An entry that was never written reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	alm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_CH)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(addr_q),
		.wr_data(ram_wdata),
		.rd_en  (in_acc),
		.rd_addr(in_addr),
		.rd_data(ram_rdata)
	);

	// Read stage: unpack the entry, take the magnitude and square it.
	always_comb begin
		entry   = entry_valid_q ? ram_rdata : '0;
		mag     = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
		sq_full = SQF_W'(mag) * SQF_W'(mag);
		sq_wide = (64'(sq_full) >> SQ_R) << SQ_L;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			acc_s1  <= entry[ACC_W-1:0];
			held_s1 <= entry[ACC_W +: LVL_W];
			age_s1  <= entry[ACC_W + LVL_W +: AGE_W];
			pk_s1   <= ACC_W'(mag) << (ACC_W - SAMPLE_BITS);
			sq_s1   <= sq_wide[ACC_W-1:0];
		end
	end

	// Multiply stage: weight the distance to the new square.
	always_comb begin
		ge   = (sq_s1 >= acc_s1);
		diff = ge ? (sq_s1 - acc_s1) : (acc_s1 - sq_s1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s2 <= MUL_W'(diff) * MUL_W'(rms_factor_q);
			ge_s2   <= ge;
		end
	end

	// Update stage: new accumulator, level and hold state, then write back.
	always_comb begin
		// A falling average rounds its step up, so the floor is toward minus infinity.
		prod_up = prod_s2 + MUL_W'(17'h0FFFF);
		if (ge_s2) begin
			acc_ms = (ACC_W + 1)'(acc_s1) + (ACC_W + 1)'(prod_s2 >> 16);
		end else begin
			acc_ms = (ACC_W + 1)'(acc_s1) - (ACC_W + 1)'(prod_up >> 16);
		end
		if (meter_mode_q) begin
			acc_sel = acc_ms;
		end else begin
			acc_sel = (ACC_W + 1)'((pk_s1 > acc_s1) ? pk_s1 : acc_s1);
		end
		acc_new = (acc_sel > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : acc_sel[ACC_W-1:0];
		lvl     = acc_new[15 +: LVL_W];
		if (lvl > FULL_Q15) begin
			lvl = FULL_Q15;
		end

		take     = (lvl >= held_s1) || (age_s1 >= hold_frames_q);
		held_new = held_s1;
		age_new  = age_s1;
		if (fe_q && hold_en) begin
			if (take) begin
				held_new = lvl;
				age_new  = '0;
			end else begin
				age_new = age_s1 + 1'b1;
			end
		end

		// Peak mode starts a fresh frame after each report.
		acc_wr    = (fe_q && !meter_mode_q) ? '0 : acc_new;
		ram_we    = (state_q == ST_UPD);
		ram_wdata = {age_new, held_new, acc_wr};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			lvl_s3  <= lvl;
			held_s3 <= held_new;
		end
	end

	alm_bar u_level_bar (
		.clk      (clk),
		.en       (state_q == ST_BAR),
		.lvl      (lvl_s3),
		.bar_width(bar_width_q),
		.vertical (vertical_q),
		.pos_q    (bar_pos)
	);

	alm_bar u_hold_bar (
		.clk      (clk),
		.en       (state_q == ST_BAR),
		.lvl      (held_s3),
		.bar_width(bar_width_q),
		.vertical (vertical_q),
		.pos_q    (hold_bar)
	);

	// The hold marker sits one pixel below the held position, never below zero.
	assign hold_pos = (hold_bar != '0) ? (hold_bar - 1'b1) : '0;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_beat_q.out_channel   <= ch_q;
			out_beat_q.level         <= lvl_s3;
			out_beat_q.bar_position  <= bar_pos;
			out_beat_q.hold_position <= hold_en ? hold_pos : '0;
			out_beat_q.hold_valid    <= hold_en;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule

// File: sim/alm_level_checker.sv
// Checker that predicts and compares the level reports of the audio level meter.
module alm_level_checker import alm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  alm_in_t              in_beat,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  alm_out_t             out_beat,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   expected_count,
	output int                   reports_checked,
	output int                   beats_seen
);

	// Shadow copies of the registers.
	logic            mode_r;
	logic [BW_W-1:0] bw_r;
	logic            vert_r;
	logic [RF_W-1:0] rf_r;
	logic [HF_W-1:0] hf_r;

	// Shadow copy of the per-channel state.
	longint unsigned  acc_q30  [MAX_CHANNELS];
	logic [LVL_W-1:0] held_lvl [MAX_CHANNELS];
	logic [AGE_W-1:0] hold_cnt [MAX_CHANNELS];

	alm_out_t pending_reports [$];
	int       n_bad;
	int       n_checked;
	int       n_beats;

	function automatic logic [BW_W-1:0] bar_from_level(input logic [LVL_W-1:0] lvl);
		longint unsigned prod;
		longint unsigned pos;
		prod = bw_r;
		prod = prod * lvl;
		if (vert_r)
			pos = longint'(bw_r) - ((prod + (FULL_Q15 - 1)) >> 15);
		else
			pos = prod >> 15;
		return pos[BW_W-1:0];
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
			REG_METER_MODE:  mode_r = val[0];
			REG_BAR_WIDTH:   bw_r = val[BW_W-1:0];
			REG_VERTICAL:    vert_r = val[0];
			REG_RMS_FACTOR:  rf_r = val[RF_W-1:0];
			REG_HOLD_FRAMES: hf_r = val[HF_W-1:0];
			default: ;
		endcase
	endtask

	// Updates the channel accumulator and, on a frame end, queues the report.
	task automatic meter_frame_report(input alm_in_t b);
		logic [SAMPLE_BITS-1:0] raw;
		longint unsigned mag, pk, sq, acc, d, lim, lvl_wide;
		logic [LVL_W-1:0] lvl;
		logic [BW_W-1:0] hp;
		alm_out_t r;
		int ch;
		ch = b.channel;
		if (ch >= MAX_CHANNELS)
			return;
		raw = b.sample;
		mag = raw;
		if (raw[SAMPLE_BITS-1])
			mag = (64'd1 << SAMPLE_BITS) - mag;
		acc = acc_q30[ch];
		if (!mode_r) begin
			pk = mag << (31 - SAMPLE_BITS);
			if (pk > acc)
				acc = pk;
		end else begin
			sq = mag * mag;
			if (2 * SAMPLE_BITS >= 32)
				sq = sq >> (2 * SAMPLE_BITS - 32);
			else
				sq = sq << (32 - 2 * SAMPLE_BITS);
			if (sq >= acc) begin
				acc = acc + (((sq - acc) * rf_r) >> 16);
			end else begin
				d = (acc - sq) * rf_r;
				acc = acc - ((d + 65535) >> 16);
			end
		end
		lim = ACC_MAX;
		if (acc > lim)
			acc = lim;
		acc_q30[ch] = acc;
		if (!b.frame_end)
			return;

		lvl_wide = acc >> 15;
		if (lvl_wide > FULL_Q15)
			lvl_wide = FULL_Q15;
		lvl = lvl_wide[LVL_W-1:0];
		r.out_channel  = b.channel;
		r.level        = lvl;
		r.bar_position = bar_from_level(lvl);
		if (hf_r != 0) begin
			if (lvl >= held_lvl[ch] || hold_cnt[ch] >= hf_r) begin
				held_lvl[ch] = lvl;
				hold_cnt[ch] = '0;
			end else begin
				hold_cnt[ch] = hold_cnt[ch] + 1'b1;
			end
			hp = bar_from_level(held_lvl[ch]);
			r.hold_position = (hp > 0) ? hp - 1'b1 : '0;
			r.hold_valid    = 1'b1;
		end else begin
			r.hold_position = '0;
			r.hold_valid    = 1'b0;
		end
		if (!mode_r)
			acc_q30[ch] = 0;
		pending_reports.push_back(r);
	endtask

	task automatic check_report(input alm_out_t got);
		alm_out_t want;
		if (pending_reports.size() == 0) begin
			n_bad++;
			if (n_bad <= 10)
				$display("error: report with none expected: ch=%0d level=%0d bar=%0d hold=%0d hv=%0d",
					got.out_channel, got.level, got.bar_position, got.hold_position,
					got.hold_valid);
			return;
		end
		want = pending_reports.pop_front();
		n_checked++;
		if (got.out_channel !== want.out_channel || got.level !== want.level ||
			got.bar_position !== want.bar_position ||
			got.hold_position !== want.hold_position ||
			got.hold_valid !== want.hold_valid) begin
			n_bad++;
			if (n_bad <= 10) begin
				$display("error: expected ch=%0d level=%0d bar=%0d hold=%0d hv=%0d",
					want.out_channel, want.level, want.bar_position, want.hold_position,
					want.hold_valid);
				$display("       actual   ch=%0d level=%0d bar=%0d hold=%0d hv=%0d",
					got.out_channel, got.level, got.bar_position, got.hold_position,
					got.hold_valid);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = 1'b0;
			bw_r   = BAR_WIDTH_RST;
			vert_r = 1'b0;
			rf_r   = RMS_FACTOR_RST;
			hf_r   = '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				acc_q30[i]  = 0;
				held_lvl[i] = '0;
				hold_cnt[i] = '0;
			end
			pending_reports.delete();
			n_bad = 0;
			n_checked = 0;
			n_beats = 0;
		end else begin
			if (cfg_wr_en)
				apply_reg(cfg_index, cfg_data);
			if (out_valid && out_ready)
				check_report(out_beat);
			if (in_valid && in_ready) begin
				n_beats++;
				meter_frame_report(in_beat);
			end
		end
		mismatch_count  <= n_bad;
		expected_count  <= pending_reports.size();
		reports_checked <= n_checked;
		beats_seen      <= n_beats;
	end

endmodule

// File: sim/audio_level_meter_peak_hold_core_tb.sv
// Testbench top: drives samples and register settings into the level meter.
module audio_level_meter_peak_hold_core_tb;
	import alm_pkg::*;

	// The whole run, including the slowest legal handshake pattern, fits well
	// inside this many cycles; anything beyond it means the block has hung.
	localparam int CYCLE_LIMIT = 800000;
	// A beat passes the read, multiply and update states and a frame-end beat
	// also bar and emit, so this many quiet cycles guarantee the block is idle.
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_BEATS = 220;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	alm_in_t              in_beat = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	alm_out_t             out_beat;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int mismatch_count;
	int expected_count;
	int reports_checked;
	int beats_seen;

	int  cycle_count = 0;
	int  settings_count = 0;
	int  ready_left = 0;
	bit  tx_gaps = 1'b1;
	bit  rx_stalls = 1'b1;
	int  frame_left [MAX_CHANNELS];

	audio_level_meter_peak_hold_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The checker sees exactly what the block sees and keeps its own model
	// of every channel; the top learns how many reports are still outstanding,
	// how many were wrong, how many were checked and how many beats were seen.
	alm_level_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_beat         (in_beat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_beat        (out_beat),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.expected_count  (expected_count),
		.reports_checked (reports_checked),
		.beats_seen      (beats_seen)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Idle lengths: mostly back to back, often a short pause, now and then
	// a long one so that gaps land on every stage of the block's sequence.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The receiver toggles ready in runs of random length. When stalls are
	// switched off for a phase it simply stays ready.
	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else if (!rx_stalls) begin
			out_ready <= 1'b1;
		end else begin
			out_ready  <= ($urandom_range(0, 99) < 65);
			ready_left <= pick_gap();
		end
	end

	// Watchdog: a run that goes past the limit has stalled somewhere.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still outstanding",
				cycle_count, expected_count);
			$display("FAILURE");
			$finish;
		end
	end

	// Samples: full-scale and near-zero values are common on purpose, since
	// they hit the clip, the negative-full-scale magnitude and the rounding
	// edges of the bar scaling.
	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 5))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				3: return -16'sd1;
				4: return 16'sd1;
				default: return -16'sd32767;
			endcase
		end
		if (r < 4)
			return ($urandom_range(0, 1) ? 16'sd1 : -16'sd1) * $signed({7'd0, 9'($urandom)});
		return 16'($urandom);
	endfunction

	function automatic logic [BW_W-1:0] pick_bar_width();
		case ($urandom_range(0, 5))
			0: return 14'd80;
			1: return 14'd8192;
			2: return 14'($urandom);
			default: return 14'($urandom_range(80, 8192));
		endcase
	endfunction

	function automatic logic [RF_W-1:0] pick_rms_factor();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'hFFFF;
			2: return RMS_FACTOR_RST;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [HF_W-1:0] pick_hold_frames();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'd1;
			3: return 16'($urandom);
			default: return 16'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic alm_in_t make_beat(input int ch, input int s, input bit fe);
		alm_in_t b;
		b.channel   = CH_W'(ch);
		b.sample    = SAMPLE_BITS'(s);
		b.frame_end = fe;
		return b;
	endfunction

	// Presents one beat, holds it until accepted, then idles for a while.
	// Valid is only lowered when a gap follows, so back-to-back beats keep
	// it high without a glitch.
	task automatic send_beat(input alm_in_t b);
		int gap;
		in_beat  <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Brings the block to idle: no beat offered, every report delivered, and
	// enough extra cycles for a beat that makes no report to finish too.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all five registers plus one unused index. Bits above a
	// register's width are filled with noise, since the block must ignore them.
	task automatic write_settings(input logic mode, input logic [BW_W-1:0] bw,
		input logic vert, input logic [RF_W-1:0] rf, input logic [HF_W-1:0] hf);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_W-1:0]     val [6];
		idx[0] = REG_METER_MODE;
		val[0] = {15'($urandom), mode};
		idx[1] = REG_BAR_WIDTH;
		val[1] = {2'($urandom), bw};
		idx[2] = REG_VERTICAL;
		val[2] = {15'($urandom), vert};
		idx[3] = REG_RMS_FACTOR;
		val[3] = rf;
		idx[4] = REG_HOLD_FRAMES;
		val[4] = hf;
		idx[5] = REG_HOLD_FRAMES + CFG_IDX_W'($urandom_range(1, 3));
		val[5] = 16'($urandom);
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		settings_count++;
	endtask

	// Random traffic is built from frames: each channel gets a frame length,
	// its samples are interleaved with other channels, and the last one is
	// marked. A small share of beats gets a random frame-end mark instead,
	// which cuts frames short at arbitrary points.
	task automatic random_phase(input int n_beats, input int ch_span);
		alm_in_t b;
		int ch;
		int r;
		for (int n = 0; n < n_beats; n++) begin
			ch = $urandom_range(0, ch_span - 1);
			if (frame_left[ch] == 0) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					frame_left[ch] = $urandom_range(1, 4);
				else if (r < 95)
					frame_left[ch] = $urandom_range(5, 12);
				else
					frame_left[ch] = $urandom_range(13, 40);
			end
			frame_left[ch]--;
			b.channel   = CH_W'(ch);
			b.sample    = rand_sample();
			b.frame_end = (frame_left[ch] == 0);
			if ($urandom_range(0, 19) == 0) begin
				b.frame_end = 1'($urandom_range(0, 1));
				if (b.frame_end)
					frame_left[ch] = 0;
			end
			send_beat(b);
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_CHANNELS; i++)
			frame_left[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: peak mode, 400 pixels, no hold. Full
		// positive and negative scale, zero, minus one, and a multi-sample
		// frame whose largest magnitude is in the middle.
		send_beat(make_beat(0, 32767, 1));
		send_beat(make_beat(7, -32768, 1));
		send_beat(make_beat(1, 0, 1));
		send_beat(make_beat(2, -1, 0));
		send_beat(make_beat(2, 5, 1));
		send_beat(make_beat(3, 100, 0));
		send_beat(make_beat(3, -20000, 0));
		send_beat(make_beat(3, 3, 1));
		send_beat(make_beat(4, -32767, 1));
		wait_idle();

		// Directed, mean square with the fastest weight, vertical bar and a
		// two-frame hold: a full-scale square followed by silence shows the
		// decay, the held maximum and its timeout.
		write_settings(1'b1, 14'd8192, 1'b1, 16'hFFFF, 16'd2);
		send_beat(make_beat(0, -32768, 1));
		repeat (4) send_beat(make_beat(0, 0, 1));
		send_beat(make_beat(5, 32767, 0));
		send_beat(make_beat(5, 32767, 1));
		send_beat(make_beat(6, 1, 1));
		send_beat(make_beat(6, -1, 1));
		send_beat(make_beat(7, -32768, 0));
		send_beat(make_beat(7, -32768, 1));
		wait_idle();

		// Random phases. The first few pin the register extremes; the rest
		// draw settings at random. Handshake pressure varies per phase, and
		// some phases crowd all traffic onto two channels so that the hold
		// logic sees long runs of frames on the same channel.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			tx_gaps   = (ph % 4 != 1);
			rx_stalls = (ph % 4 != 1) && (ph % 4 != 2);
			case (ph)
				0: write_settings(1'b0, 14'd80, 1'b0, RMS_FACTOR_RST, 16'd1);
				1: write_settings(1'b1, 14'd8192, 1'b1, 16'hFFFF, 16'hFFFF);
				2: write_settings(1'b1, 14'h3FFF, 1'b0, 16'd0, 16'd3);
				3: write_settings(1'b0, 14'd0, 1'b1, 16'd1, 16'd0);
				default: write_settings(1'($urandom_range(0, 1)), pick_bar_width(),
					1'($urandom_range(0, 1)), pick_rms_factor(), pick_hold_frames());
			endcase
			random_phase(PHASE_BEATS, (ph % 3 == 2) ? 2 : MAX_CHANNELS);
			wait_idle();
		end

		$display("Sent %0d sample beats and checked %0d level reports across %0d settings,",
			beats_seen, reports_checked, settings_count);
		$display("covering both meter modes, both bar orientations and hold on, off and timed out.");
		if (mismatch_count == 0 && expected_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d reports outstanding", mismatch_count, expected_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
